[hdl/frg_pkg.sv]
// frg_pkg: shared widths and payload types for the fraction reduce gcd unit
// no dependencies; imported by fraction_reduce_gcd_unit
package frg_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] frg_word_t;
  typedef logic [CNT_W-1:0]      frg_cnt_t;

  typedef struct packed {
    frg_word_t numerator_in;
    frg_word_t denominator_in;
  } frg_in_t;

  typedef struct packed {
    frg_word_t numerator_out;
    frg_word_t denominator_out;
    frg_word_t common_divisor;
    logic      zero_error;
  } frg_out_t;

endpackage

[hdl/fraction_reduce_gcd_unit.sv]
// fraction_reduce_gcd_unit: reduces an unsigned fraction to lowest terms
// depends on frg_pkg (widths, payload structs)
//
//   channel  direction  handshake              payload
//   src      input      src_valid / src_ready  frg_in_t  (numerator, denominator)
//   res      output     res_valid / res_ready  frg_out_t (reduced pair, gcd, error)
//
// one shared subtractor does all the work under a small sequencer:
//   binary gcd, where each step halves an operand, strips a common factor
//   of two, or swaps ahead of a subtract that halves, ending on an equal
//   compare; then the common power of two is restored, then two restoring
//   divisions (numerator, then denominator, by the gcd), then the result
//   is loaded. a zero operand skips straight to the result load. src_ready
//   is high only while the sequencer is idle.
// reset (rst, synchronous) clears the sequencer and the result valid flag.
// a result waiting on res_ready does not block the next src transfer; only
// the finish step waits while the result register is still occupied.
module fraction_reduce_gcd_unit
  import frg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  frg_in_t  src_data,
  output logic     res_valid,
  input  logic     res_ready,
  output frg_out_t res_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_SCALE,
    S_DIVN,
    S_DIVD,
    S_FIN
  } state_t;

  state_t    state;
  frg_word_t a;         // gcd operand, later the divisor
  frg_word_t b;         // gcd operand, later the division remainder
  frg_word_t q;         // dividend / quotient shift register
  frg_word_t op_num;
  frg_word_t op_den;
  frg_word_t quot_num;
  frg_cnt_t  k;         // common power of two
  frg_cnt_t  cnt;       // division bit counter
  logic      zflag;

  // shared subtractor, two extra bits so the shifted remainder fits and the sign shows in both uses
  logic [DATA_WIDTH+1:0] sub_x;
  logic [DATA_WIDTH+1:0] sub_y;
  logic [DATA_WIDTH+1:0] sub_res;
  logic                  sub_neg;
  logic                  sub_zero;

  // next values of one division step
  frg_word_t div_rem_next;
  frg_word_t div_q_next;

  always_comb begin
    if (state == S_DIVN || state == S_DIVD) begin
      // shifted partial remainder minus divisor
      sub_x = {1'b0, b, q[DATA_WIDTH-1]};
      sub_y = {2'b00, a};
    end else begin
      sub_x = {2'b00, a};
      sub_y = {2'b00, b};
    end
    sub_res  = sub_x - sub_y;
    sub_neg  = sub_res[DATA_WIDTH+1];
    sub_zero = (sub_res == '0);
  end

  always_comb begin
    if (!sub_neg) begin
      div_rem_next = sub_res[DATA_WIDTH-1:0];
      div_q_next   = {q[DATA_WIDTH-2:0], 1'b1};
    end else begin
      div_rem_next = {b[DATA_WIDTH-2:0], q[DATA_WIDTH-1]};
      div_q_next   = {q[DATA_WIDTH-2:0], 1'b0};
    end
  end

  assign src_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // the finish step reloads the register itself in the same cycle
      if (res_valid && res_ready && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (src_valid) begin
            op_num <= src_data.numerator_in;
            op_den <= src_data.denominator_in;
            k      <= '0;
            if (src_data.numerator_in == '0 || src_data.denominator_in == '0) begin
              // no divisor defined: echo the inputs
              quot_num <= src_data.numerator_in;
              q        <= src_data.denominator_in;
              a        <= '0;
              zflag    <= 1'b1;
              state    <= S_FIN;
            end else begin
              a     <= src_data.numerator_in;
              b     <= src_data.denominator_in;
              zflag <= 1'b0;
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (!a[0] && !b[0]) begin
            // common factor of two
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (sub_zero) begin
            state <= S_SCALE;
          end else if (sub_neg) begin
            a <= b;
            b <= a;
          end else begin
            // odd minus odd is even, halve it right away
            a <= sub_res[DATA_WIDTH:1];
          end
        end
        S_SCALE: begin
          if (k == '0) begin
            b     <= '0;
            q     <= op_num;
            cnt   <= CNT_W'(DATA_WIDTH - 1);
            state <= S_DIVN;
          end else begin
            a <= a << 1;
            k <= k - 1'b1;
          end
        end
        S_DIVN: begin
          if (cnt == '0) begin
            quot_num <= div_q_next;
            b        <= '0;
            q        <= op_den;
            cnt      <= CNT_W'(DATA_WIDTH - 1);
            state    <= S_DIVD;
          end else begin
            b   <= div_rem_next;
            q   <= div_q_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVD: begin
          b <= div_rem_next;
          q <= div_q_next;
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          // wait only while an older result still sits in the register
          if (!res_valid || res_ready) begin
            res_data.numerator_out   <= quot_num;
            res_data.denominator_out <= q;
            res_data.common_divisor  <= a;
            res_data.zero_error      <= zflag;
            res_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // both gcd operands stay nonzero, else the loop would never end
  assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD) |-> (a != '0 && b != '0))
    else $error("gcd operand reached zero");

  // restoring division keeps the remainder below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN || state == S_DIVD) |-> (b < a))
    else $error("division remainder not below divisor");

  // a valid result has a zero divisor exactly when it flags an error
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_data.common_divisor == '0) == res_data.zero_error))
    else $error("divisor and error flag disagree");

  // a src transfer starts work, so the port closes on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (src_valid && src_ready) |=> !src_ready)
    else $error("src_ready stayed high after a transfer");
`endif

endmodule
